### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the wsp_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, ignored while reset is asserted.
`define ASSERT_CLKRST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Check a property at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### src/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Types, character codes and helper functions of the whitespace packer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] PRE_LEN  = 3'd4;
  localparam logic [2:0] CODE_LEN = 3'd5;

  // Tag matcher phases.
  typedef enum logic [3:0] {
    TM_IDLE  = 4'b0001,
    TM_LT    = 4'b0010,
    TM_SLASH = 4'b0100,
    TM_WORD  = 4'b1000
  } tm_phase_e;

  // One classified transaction: optional run byte, then the main result.
  typedef struct packed {
    logic       has_run;
    logic [7:0] run_byte;
    logic [7:0] main_byte;
    logic       main_valid;
    logic       main_last;
  } wsp_rec_t;

  // One result on the output channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
  } wsp_res_t;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) || (b == CH_SP);
  endfunction

  function automatic logic is_sym(input logic [7:0] b);
    case (b)
      8'h3C, 8'h3E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2F, 8'h22, 8'h3A, 8'h2C,
      8'h3B: is_sym = 1'b1;
      default: is_sym = 1'b0;
    endcase
  endfunction

  // Expected byte at a position of "pre>" (word 0) or "code>" (word 1).
  function automatic logic [7:0] tag_char(input logic word, input logic [2:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    if (word) begin
      case (pos)
        3'd0: c = 8'h63;
        3'd1: c = 8'h6F;
        3'd2: c = 8'h64;
        3'd3: c = 8'h65;
        3'd4: c = CH_GT;
        default: c = CH_NUL;
      endcase
    end else begin
      case (pos)
        3'd0: c = 8'h70;
        3'd1: c = 8'h72;
        3'd2: c = 8'h65;
        3'd3: c = CH_GT;
        default: c = CH_NUL;
      endcase
    end
    tag_char = c;
  endfunction

endpackage

`default_nettype wire

### src/wsp_intf.sv
// ----------------------------------------------------------------------------
// wsp_intf
// Valid/ready channel interfaces of the whitespace packer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface wsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                  output ready);
endinterface

interface wsp_cfg_if;
  logic valid;
  logic ready;
  logic html_compact_mode;
  modport source (output valid, output html_compact_mode, input ready);
  modport sink   (input valid, input html_compact_mode, output ready);
endinterface

`default_nettype wire

### src/wsp_front.sv
// ----------------------------------------------------------------------------
// wsp_front
// Accepts text bytes, tracks whitespace runs and verbatim tags, and queues
// one classified record per byte that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_front import wsp_pkg::*; #(
  parameter int NEST_LIMIT = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       html_mode_i,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            in_ready_o,
  output logic            push_valid_o,
  output wsp_rec_t        push_rec_o,
  input  wire logic       push_ready_i
);

  localparam int DEPTH_W = $clog2(NEST_LIMIT + 1);

  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               lock_q, lock_d;
  tm_phase_e          phase_q, phase_d;
  logic               close_q, close_d;
  logic               word_q, word_d;
  logic [2:0]         pos_q, pos_d;
  logic               run_q, run_d;
  logic               longer_q, longer_d;
  logic               lf_q, lf_d;
  logic [7:0]         held_q, held_d;
  logic               started_q, started_d;
  logic               prev_sym_q, prev_sym_d;

  logic       accept;
  logic       level0;
  logic       absorb;
  logic       try_word;
  logic       fallback;
  logic       tag_hit;
  logic [2:0] word_len;
  logic [2:0] pos_inc;
  logic [7:0] collapsed;
  wsp_rec_t   rec;
  logic       rec_valid;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign level0     = !lock_q && (depth_q == '0);
  assign absorb     = is_ws(in_byte_i) && level0;
  assign word_len   = word_q ? CODE_LEN : PRE_LEN;
  assign pos_inc    = pos_q + 3'd1;

  always_comb begin
    depth_d    = depth_q;
    lock_d     = lock_q;
    phase_d    = phase_q;
    close_d    = close_q;
    word_d     = word_q;
    pos_d      = pos_q;
    run_d      = run_q;
    longer_d   = longer_q;
    lf_d       = lf_q;
    held_d     = held_q;
    started_d  = started_q;
    prev_sym_d = prev_sym_q;
    try_word   = 1'b0;
    fallback   = 1'b0;
    tag_hit    = 1'b0;
    collapsed  = CH_SP;
    rec        = '0;
    rec_valid  = 1'b0;

    if (accept) begin
      if (absorb) begin
        phase_d = TM_IDLE;
        run_d   = 1'b1;
        if (!run_q) begin
          held_d   = in_byte_i;
          longer_d = 1'b0;
          lf_d     = (in_byte_i == CH_LF);
        end else begin
          longer_d = 1'b1;
          lf_d     = lf_q || (in_byte_i == CH_LF);
        end
        collapsed = lf_d ? CH_LF : CH_SP;
        if (in_last_i) begin
          rec_valid      = 1'b1;
          rec.main_last  = 1'b1;
          if (html_mode_i) begin
            rec.main_byte  = CH_NUL;
            rec.main_valid = 1'b0;
          end else begin
            rec.main_valid = 1'b1;
            rec.main_byte  = (!started_q || longer_d) ? collapsed : held_d;
          end
        end
      end else begin
        collapsed      = lf_q ? CH_LF : CH_SP;
        rec_valid      = 1'b1;
        rec.main_byte  = in_byte_i;
        rec.main_valid = 1'b1;
        rec.main_last  = in_last_i;
        if (run_q) begin
          run_d = 1'b0;
          if (html_mode_i) begin
            rec.has_run  = started_q && !prev_sym_q && !is_sym(in_byte_i);
            rec.run_byte = collapsed;
          end else begin
            rec.has_run  = 1'b1;
            rec.run_byte = (!started_q || longer_q) ? collapsed : held_q;
          end
        end

        case (phase_q)
          TM_LT: begin
            if (in_byte_i == CH_SLASH) begin
              close_d = 1'b1;
              phase_d = TM_SLASH;
            end else begin
              close_d  = 1'b0;
              try_word = 1'b1;
            end
          end
          TM_SLASH: try_word = 1'b1;
          TM_WORD: begin
            if ((pos_q < word_len) && (in_byte_i == tag_char(word_q, pos_q))) begin
              pos_d = pos_inc;
              if (pos_inc == word_len) begin
                phase_d = TM_IDLE;
                tag_hit = 1'b1;
              end
            end else begin
              fallback = 1'b1;
            end
          end
          default: fallback = 1'b1;
        endcase

        if (try_word) begin
          if (in_byte_i == CH_P) begin
            word_d  = 1'b0;
            pos_d   = 3'd1;
            phase_d = TM_WORD;
          end else if (in_byte_i == CH_C) begin
            word_d  = 1'b1;
            pos_d   = 3'd1;
            phase_d = TM_WORD;
          end else begin
            fallback = 1'b1;
          end
        end
        if (fallback) begin
          phase_d = (in_byte_i == CH_LT) ? TM_LT : TM_IDLE;
        end

        if (tag_hit && !lock_q) begin
          if (!close_q) begin
            if (depth_q < DEPTH_W'(NEST_LIMIT)) begin
              depth_d = depth_q + DEPTH_W'(1);
            end
          end else if (depth_q == '0) begin
            lock_d = 1'b1;
          end else begin
            depth_d = depth_q - DEPTH_W'(1);
          end
        end
        prev_sym_d = is_sym(in_byte_i);
        started_d  = 1'b1;
      end

      if (in_last_i) begin
        depth_d    = '0;
        lock_d     = 1'b0;
        phase_d    = TM_IDLE;
        close_d    = 1'b0;
        word_d     = 1'b0;
        pos_d      = 3'd0;
        run_d      = 1'b0;
        longer_d   = 1'b0;
        lf_d       = 1'b0;
        held_d     = CH_NUL;
        started_d  = 1'b0;
        prev_sym_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= '0;
      lock_q     <= 1'b0;
      phase_q    <= TM_IDLE;
      close_q    <= 1'b0;
      word_q     <= 1'b0;
      pos_q      <= 3'd0;
      run_q      <= 1'b0;
      longer_q   <= 1'b0;
      lf_q       <= 1'b0;
      held_q     <= CH_NUL;
      started_q  <= 1'b0;
      prev_sym_q <= 1'b0;
    end else begin
      depth_q    <= depth_d;
      lock_q     <= lock_d;
      phase_q    <= phase_d;
      close_q    <= close_d;
      word_q     <= word_d;
      pos_q      <= pos_d;
      run_q      <= run_d;
      longer_q   <= longer_d;
      lf_q       <= lf_d;
      held_q     <= held_d;
      started_q  <= started_d;
      prev_sym_q <= prev_sym_d;
    end
  end

  assign push_valid_o = rec_valid;
  assign push_rec_o   = rec;

endmodule

`default_nettype wire

### src/wsp_queue.sv
// ----------------------------------------------------------------------------
// wsp_queue
// Two-entry record queue that decouples the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_queue import wsp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_valid_i,
  input  wire wsp_rec_t push_rec_i,
  output logic          push_ready_o,
  output logic          head_valid_o,
  output wsp_rec_t      head_rec_o,
  input  wire logic     pop_i
);

  wsp_rec_t   entries_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_rec_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/wsp_back.sv
// ----------------------------------------------------------------------------
// wsp_back
// Expands queued records into one or two results and drives the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_back import wsp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     head_valid_i,
  input  wire wsp_rec_t head_rec_i,
  output logic          pop_o,
  output logic          out_valid_o,
  output wsp_res_t      out_res_o,
  input  wire logic     out_ready_i
);

  logic     out_valid_q;
  logic     run_done_q;
  wsp_res_t res_q, res_d;
  logic     load;
  logic     take_run;

  assign load     = head_valid_i && (!out_valid_q || out_ready_i);
  assign take_run = head_rec_i.has_run && !run_done_q;
  assign pop_o    = load && !take_run;

  always_comb begin
    if (take_run) begin
      res_d.out_byte   = head_rec_i.run_byte;
      res_d.byte_valid = 1'b1;
      res_d.out_last   = 1'b0;
    end else begin
      res_d.out_byte   = head_rec_i.main_byte;
      res_d.byte_valid = head_rec_i.main_valid;
      res_d.out_last   = head_rec_i.main_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      run_done_q  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        run_done_q  <= take_run;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

### src/whitespace_packer_top.sv
// ----------------------------------------------------------------------------
// whitespace_packer_top
// Collapses whitespace runs in a text byte stream, with verbatim copying
// inside pre and code tags and an optional HTML compact mode.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one text byte per transaction; in_last flags the final byte.
//   out_o  carries packed bytes; byte_valid low marks a bare end marker,
//          out_last flags the final result of a text.
//   cfg_i  writes html_compact_mode; write it only while the block is idle.
// Path: a result reaches out_o through the queue, written at the edge that
//   accepts the byte that causes it, and then the output register, which
//   loads from the queue head when it is free. Bytes inside a whitespace run
//   are absorbed and emit nothing until the run resolves.
// Throughput: one byte per cycle while the queue has room; the output
//   register sends one result per cycle while out_o.ready is high, so a
//   byte that also releases a held run yields two results.
// Reset: all text state clears and HTML compact mode is off. Text state
//   clears again after every final byte.
// Stall: the output holds while out_o.ready is low; the two-entry queue
//   keeps accepting until full, then in_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module whitespace_packer_top import wsp_pkg::*; #(
  parameter int NEST_LIMIT = 255
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wsp_in_if.sink     in_i,
  wsp_out_if.source  out_o,
  wsp_cfg_if.sink    cfg_i
);

  logic     mode_q;
  logic     push_valid;
  logic     push_ready;
  wsp_rec_t push_rec;
  logic     head_valid;
  wsp_rec_t head_rec;
  logic     pop;
  wsp_res_t out_res;
  logic     out_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.html_compact_mode;
    end
  end

  wsp_front #(
    .NEST_LIMIT (NEST_LIMIT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .html_mode_i  (mode_q),
    .in_valid_i   (in_i.valid),
    .in_byte_i    (in_i.in_byte),
    .in_last_i    (in_i.in_last),
    .in_ready_o   (in_i.ready),
    .push_valid_o (push_valid),
    .push_rec_o   (push_rec),
    .push_ready_i (push_ready)
  );

  wsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_rec_i   (push_rec),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_rec_o   (head_rec),
    .pop_i        (pop)
  );

  wsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_rec_i   (head_rec),
    .pop_o        (pop),
    .out_valid_o  (out_valid),
    .out_res_o    (out_res),
    .out_ready_i  (out_o.ready)
  );

  assign out_o.valid      = out_valid;
  assign out_o.out_byte   = out_res.out_byte;
  assign out_o.byte_valid = out_res.byte_valid;
  assign out_o.out_last   = out_res.out_last;

endmodule

`default_nettype wire

### src/wsp_checker.sv
// ----------------------------------------------------------------------------
// wsp_checker
// Port-level checks of the whitespace packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wsp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       byte_valid_i,
  input wire logic       out_last_i,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_i
);

  // Hold a stalled result.
  `ASSERT_CLKRST(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(byte_valid_i) && $stable(out_last_i))

  // A bare end marker always closes the text and carries a zero byte.
  `ASSERT_CLKRST(a_bare_marker, clk_i, rst_ni, out_valid_i && !byte_valid_i |-> out_last_i && (out_byte_i == 8'h00))

  // No result in the cycle after reset is seen.
  `ASSERT_CLK(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_i)

  // Never refuse a configuration write.
  `ASSERT_CLKRST(a_cfg_ready, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_i)

endmodule

bind whitespace_packer_top wsp_checker u_wsp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .byte_valid_i (out_o.byte_valid),
  .out_last_i   (out_o.out_last),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready)
);

`default_nettype wire
